// ----- hw/rtl/r2fft_pkg.sv -----
// Shared types, codes and the twiddle table generator for the radix-2 FFT core.
// No dependencies; imported by the controller, the datapath and the top level.

package r2fft_pkg;

   localparam int LOG2_W  = 4;    // width of the log2_points register
   localparam int CSR_W   = 4;    // widest configuration register
   localparam int CSR_AW  = 2;    // configuration index width
   localparam int ACT_W   = 2;
   localparam int TW_W    = 16;   // Q1.15 twiddle part
   localparam int TW_FRAC = 15;

   localparam logic [LOG2_W-1:0] LOG2_RESET = 4'd10;

   localparam logic [CSR_AW-1:0] CSR_LOG2_POINTS       = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_TRANSFORM_FORWARD = 2'd1;

   localparam logic [ACT_W-1:0] ACT_LOAD      = 2'd0;
   localparam logic [ACT_W-1:0] ACT_TRANSFORM = 2'd1;
   localparam logic [ACT_W-1:0] ACT_READ      = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_READ,
      ST_PERM_RD_I,
      ST_PERM_RD_R,
      ST_PERM_WR_I,
      ST_PERM_WR_R,
      ST_BF_RD_A,
      ST_BF_RD_B,
      ST_BF_LB,
      ST_BF_M0,
      ST_BF_M1,
      ST_BF_M2,
      ST_BF_M3,
      ST_BF_M4,
      ST_BF_WR_A,
      ST_BF_WR_B,
      ST_FIN_RD,
      ST_FIN_WR,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD,
      DP_LATCH_A,
      DP_LATCH_B,
      DP_MUL0,
      DP_MUL1,
      DP_MUL2,
      DP_MUL3,
      DP_MUL4,
      DP_WR_RDATA,
      DP_WR_A,
      DP_WR_SUM,
      DP_WR_DIFF,
      DP_WR_SCALED
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      fwd;
      logic      accept;
      logic      clear_clip;
      logic      rsp_load;
      logic      rsp_read;
   } dp_cmd_type;

   localparam logic [63:0] PI_Q32  = 64'd13493037705;
   localparam logic [63:0] Q30_ONE = 64'd1 << 30;

   // Q30 Taylor series, argument in 0..pi/4
   function automatic logic [63:0] q30_sin(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      x2 = (x * x) >> 30;
      t  = x;
      s  = x;
      t = ((t * x2) >> 30) / 64'd6;   s = s - t;
      t = ((t * x2) >> 30) / 64'd20;  s = s + t;
      t = ((t * x2) >> 30) / 64'd42;  s = s - t;
      t = ((t * x2) >> 30) / 64'd72;  s = s + t;
      t = ((t * x2) >> 30) / 64'd110; s = s - t;
      t = ((t * x2) >> 30) / 64'd156; s = s + t;
      t = ((t * x2) >> 30) / 64'd210; s = s - t;
      return s;
   endfunction

   function automatic logic [63:0] q30_cos(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      s  = Q30_ONE;
      t = ((t * x2) >> 30) / 64'd2;   s = s - t;
      t = ((t * x2) >> 30) / 64'd12;  s = s + t;
      t = ((t * x2) >> 30) / 64'd30;  s = s - t;
      t = ((t * x2) >> 30) / 64'd56;  s = s + t;
      t = ((t * x2) >> 30) / 64'd90;  s = s - t;
      t = ((t * x2) >> 30) / 64'd132; s = s + t;
      t = ((t * x2) >> 30) / 64'd182; s = s - t;
      return s;
   endfunction

   function automatic logic [63:0] angle_q30(input logic [63:0] k, input int unsigned maxlog);
      return (((k * PI_Q32 * 64'd2) >> maxlog) + 64'd2) >> 2;
   endfunction

   // {cos, sin} magnitudes for k in the first quadrant
   function automatic logic [127:0] quarter(input logic [63:0] k, input int unsigned maxlog);
      logic [63:0] m;
      logic [63:0] a;
      m = 64'd1 << maxlog;
      if ((k << 3) <= m) begin
         a = angle_q30(k, maxlog);
         return {q30_cos(a), q30_sin(a)};
      end else begin
         a = angle_q30((m >> 2) - k, maxlog);
         return {q30_sin(a), q30_cos(a)};
      end
   endfunction

   function automatic logic [TW_W-1:0] quantize(input logic [63:0] v);
      logic [63:0] q;
      q = (v + (64'd1 << 14)) >> 15;
      return (q > 64'd32767) ? 16'd32767 : q[TW_W-1:0];
   endfunction

   // Twiddle table entry k: {cos, sin}, Q1.15
   function automatic logic [2*TW_W-1:0] tw_entry(input int unsigned k,
                                                 input int unsigned maxlog);
      logic [63:0]     m;
      logic [63:0]     kk;
      logic [127:0]    cs;
      logic [TW_W-1:0] c;
      m  = 64'd1 << maxlog;
      kk = 64'(k);
      if ((kk << 2) <= m) begin
         cs = quarter(kk, maxlog);
         c  = quantize(cs[127:64]);
      end else begin
         cs = quarter((m >> 1) - kk, maxlog);
         c  = -quantize(cs[127:64]);
      end
      return {c, quantize(cs[63:0])};
   endfunction

endpackage

// ----- hw/rtl/r2fft_ctrl.sv -----
// Sequencer for the radix-2 FFT core: handshakes, configuration registers,
// and the permute / butterfly / scale passes. Uses r2fft_pkg.

module r2fft_ctrl
   import r2fft_pkg::*;
#(
   parameter int MAX_LOG2_POINTS = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [ACT_W-1:0]           req_action,
   input  logic [MAX_LOG2_POINTS-1:0] req_point_index,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic                       csr_write_en,
   input  logic [CSR_AW-1:0]          csr_index,
   input  logic [CSR_W-1:0]           csr_wdata,
   output dp_cmd_type                 cmd,
   output logic [MAX_LOG2_POINTS-1:0] rd_addr,
   output logic [MAX_LOG2_POINTS-1:0] wr_addr,
   output logic [((MAX_LOG2_POINTS > 1) ? MAX_LOG2_POINTS-1 : 1)-1:0] tw_addr
);

   localparam int AW   = MAX_LOG2_POINTS;
   localparam int TWAW = (AW > 1) ? AW - 1 : 1;
   localparam logic [LOG2_W-1:0] MAXL = LOG2_W'(MAX_LOG2_POINTS);

   state_type         state_ff, state_in;
   logic [LOG2_W-1:0] log2_ff;
   logic              fwd_ff;
   logic [LOG2_W-1:0] lsel_ff, lsel_in;
   logic [AW-1:0]     mask_ff, mask_in;
   logic [AW-1:0]     cnt_ff, cnt_in;
   logic [LOG2_W-1:0] stage_ff, stage_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [LOG2_W-1:0] l_eff;
   logic [AW-1:0]     rev_full, perm_r;
   logic [AW-1:0]     hmask, hbit, jv, bf_a, bf_b, twx;
   logic              accept, last_cnt, last_bf, last_stage;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         log2_ff      <= LOG2_RESET;
         fwd_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_LOG2_POINTS:       log2_ff <= csr_wdata;
               CSR_TRANSFORM_FORWARD: fwd_ff  <= csr_wdata[0];
               default: ;
            endcase
         end
      end
      lsel_ff  <= lsel_in;
      mask_ff  <= mask_in;
      cnt_ff   <= cnt_in;
      stage_ff <= stage_in;
   end

   always_comb begin
      l_eff = (log2_ff == '0) ? LOG2_W'(1) : ((log2_ff > MAXL) ? MAXL : log2_ff);
      for (int b = 0; b < AW; b++) begin
         rev_full[b] = cnt_ff[AW-1-b];
      end
      perm_r     = rev_full >> (MAXL - lsel_ff);
      hmask      = ~({AW{1'b1}} << stage_ff);
      hbit       = AW'(1) << stage_ff;
      jv         = cnt_ff & hmask;
      bf_a       = ((cnt_ff & ~hmask) << 1) | jv;
      bf_b       = bf_a | hbit;
      twx        = jv << (MAXL - LOG2_W'(1) - stage_ff);
      last_cnt   = (cnt_ff == mask_ff);
      last_bf    = (cnt_ff == (mask_ff >> 1));
      last_stage = (stage_ff == (lsel_ff - LOG2_W'(1)));
   end

   always_comb begin
      state_in     = state_ff;
      lsel_in      = lsel_ff;
      mask_in      = mask_ff;
      cnt_in       = cnt_ff;
      stage_in     = stage_ff;
      cmd          = '{op: DP_NOP, fwd: fwd_ff, accept: 1'b0, clear_clip: 1'b0,
                       rsp_load: 1'b0, rsp_read: 1'b0};
      rd_addr      = cnt_ff;
      wr_addr      = cnt_ff;
      tw_addr      = twx[TWAW-1:0];
      req_ready    = 1'b0;
      accept       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready  = !rsp_valid_ff || rsp_ready;
            accept     = req_ready && req_valid;
            rd_addr    = req_point_index;
            wr_addr    = req_point_index;
            cmd.accept = accept;
            if (accept) begin
               case (req_action)
                  ACT_LOAD: begin
                     cmd.op       = DP_LOAD;
                     cmd.rsp_load = 1'b1;
                  end
                  ACT_TRANSFORM: begin
                     cmd.clear_clip = 1'b1;
                     lsel_in        = l_eff;
                     mask_in        = ~({AW{1'b1}} << l_eff);
                     cnt_in         = '0;
                     stage_in       = '0;
                     state_in       = ST_PERM_RD_I;
                  end
                  ACT_READ: state_in = ST_READ;
                  default:  cmd.rsp_load = 1'b1;
               endcase
            end
         end
         ST_READ: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_read = 1'b1;
            state_in     = ST_IDLE;
         end
         // swap each pair once, from the lower index
         ST_PERM_RD_I: begin
            if (cnt_ff < perm_r) begin
               state_in = ST_PERM_RD_R;
            end else if (last_cnt) begin
               cnt_in   = '0;
               state_in = ST_BF_RD_A;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         ST_PERM_RD_R: begin
            rd_addr  = perm_r;
            cmd.op   = DP_LATCH_A;
            state_in = ST_PERM_WR_I;
         end
         ST_PERM_WR_I: begin
            cmd.op   = DP_WR_RDATA;
            state_in = ST_PERM_WR_R;
         end
         ST_PERM_WR_R: begin
            cmd.op  = DP_WR_A;
            wr_addr = perm_r;
            if (last_cnt) begin
               cnt_in   = '0;
               state_in = ST_BF_RD_A;
            end else begin
               cnt_in   = cnt_ff + AW'(1);
               state_in = ST_PERM_RD_I;
            end
         end
         ST_BF_RD_A: begin
            rd_addr  = bf_a;
            state_in = ST_BF_RD_B;
         end
         ST_BF_RD_B: begin
            rd_addr  = bf_b;
            cmd.op   = DP_LATCH_A;
            state_in = ST_BF_LB;
         end
         ST_BF_LB: begin
            cmd.op   = DP_LATCH_B;
            state_in = ST_BF_M0;
         end
         ST_BF_M0: begin
            cmd.op   = DP_MUL0;
            state_in = ST_BF_M1;
         end
         ST_BF_M1: begin
            cmd.op   = DP_MUL1;
            state_in = ST_BF_M2;
         end
         ST_BF_M2: begin
            cmd.op   = DP_MUL2;
            state_in = ST_BF_M3;
         end
         ST_BF_M3: begin
            cmd.op   = DP_MUL3;
            state_in = ST_BF_M4;
         end
         ST_BF_M4: begin
            cmd.op   = DP_MUL4;
            state_in = ST_BF_WR_A;
         end
         ST_BF_WR_A: begin
            cmd.op   = DP_WR_SUM;
            wr_addr  = bf_a;
            state_in = ST_BF_WR_B;
         end
         ST_BF_WR_B: begin
            cmd.op  = DP_WR_DIFF;
            wr_addr = bf_b;
            if (!last_bf) begin
               cnt_in   = cnt_ff + AW'(1);
               state_in = ST_BF_RD_A;
            end else if (!last_stage) begin
               cnt_in   = '0;
               stage_in = stage_ff + LOG2_W'(1);
               state_in = ST_BF_RD_A;
            end else begin
               cnt_in   = '0;
               state_in = ST_FIN_RD;
            end
         end
         ST_FIN_RD: state_in = ST_FIN_WR;
         ST_FIN_WR: begin
            cmd.op = DP_WR_SCALED;
            if (last_cnt) begin
               state_in = ST_DONE;
            end else begin
               cnt_in   = cnt_ff + AW'(1);
               state_in = ST_FIN_RD;
            end
         end
         ST_DONE: begin
            cmd.rsp_load = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = cmd.rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hw/rtl/r2fft_dp.sv -----
// Datapath of the radix-2 FFT core: sample memory, twiddle table, one shared
// multiplier, butterfly rounding, final scaling and the result register.
// Uses r2fft_pkg; driven by r2fft_ctrl.

module r2fft_dp
   import r2fft_pkg::*;
#(
   parameter int MAX_LOG2_POINTS = 10,
   parameter int SAMPLE_WIDTH    = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  dp_cmd_type                     cmd,
   input  logic [MAX_LOG2_POINTS-1:0]     rd_addr,
   input  logic [MAX_LOG2_POINTS-1:0]     wr_addr,
   input  logic [((MAX_LOG2_POINTS > 1) ? MAX_LOG2_POINTS-1 : 1)-1:0] tw_addr,
   input  logic [MAX_LOG2_POINTS-1:0]     req_point_index,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_real,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_imag,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_bin_real,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_bin_imag,
   output logic [MAX_LOG2_POINTS-1:0]     rsp_echoed_index,
   output logic                           rsp_saturated
);

   localparam int AW       = MAX_LOG2_POINTS;
   localparam int TWAW     = (AW > 1) ? AW - 1 : 1;
   localparam int TW_DEPTH = 1 << TWAW;
   localparam int DEPTH    = 1 << AW;
   // inverse transforms grow one bit per stage; keep headroom for that
   localparam int WW       = SAMPLE_WIDTH + MAX_LOG2_POINTS + 2;
   localparam int PW       = WW + TW_W;
   localparam int EW       = PW + 3;

   logic [2*WW-1:0]        mem [DEPTH];
   logic [2*WW-1:0]        rdata_ff;
   logic [2*TW_W-1:0]      tw_rom [TW_DEPTH];
   logic [2*TW_W-1:0]      tw_ff;
   logic signed [WW-1:0]   a_re_ff, a_im_ff, b_re_ff, b_im_ff;
   logic signed [PW-1:0]   p_ff, p_in;
   logic signed [PW:0]     tr_ff, ti_ff;
   logic                   clip_ff, clip_in;
   logic [AW-1:0]          idx_ff;
   logic signed [SAMPLE_WIDTH-1:0] bin_re_ff, bin_im_ff;
   logic [AW-1:0]          eidx_ff;
   logic                   sat_ff;

   logic signed [WW-1:0]   rd_re, rd_im, mul_x;
   logic signed [TW_W-1:0] tw_c, tw_s, mul_w;
   logic signed [SAMPLE_WIDTH-1:0] sc_re, sc_im;
   logic                   sc_clip_re, sc_clip_im;
   logic                   wr_en;
   logic [2*WW-1:0]        wr_data;

   genvar g;
   generate
      for (g = 0; g < TW_DEPTH; g++) begin : g_tw
         localparam logic [2*TW_W-1:0] TWV = tw_entry(g, MAX_LOG2_POINTS);
         assign tw_rom[g] = TWV;
      end
   endgenerate

   // a*2^15 +/- t, rounded half up to the sample scale (extra halving when forward)
   function automatic logic signed [WW-1:0] bf_round(input logic signed [WW-1:0] a,
                                                    input logic signed [PW:0] t,
                                                    input logic sub,
                                                    input logic fwd);
      logic signed [EW-1:0] s;
      logic signed [EW-1:0] r;
      s = (EW'(a) <<< TW_FRAC) + (sub ? -EW'(t) : EW'(t));
      if (fwd) begin
         r = (s + (EW'(1) <<< TW_FRAC)) >>> (TW_FRAC + 1);
      end else begin
         r = (s + (EW'(1) <<< (TW_FRAC - 1))) >>> TW_FRAC;
      end
      return r[WW-1:0];
   endfunction

   function automatic logic [SAMPLE_WIDTH:0] scale_clamp(input logic signed [WW-1:0] x,
                                                        input logic fwd);
      logic signed [WW:0] y;
      logic signed [WW:0] hi;
      logic signed [WW:0] lo;
      y  = fwd ? ((WW+1)'(x) + (WW+1)'(1)) >>> 1 : (WW+1)'(x) <<< 1;
      hi = (WW+1)'((1 << (SAMPLE_WIDTH - 1)) - 1);
      lo = -hi - (WW+1)'(1);
      if (y > hi) return {1'b1, hi[SAMPLE_WIDTH-1:0]};
      if (y < lo) return {1'b1, lo[SAMPLE_WIDTH-1:0]};
      return {1'b0, y[SAMPLE_WIDTH-1:0]};
   endfunction

   always_comb begin
      rd_re = rdata_ff[WW-1:0];
      rd_im = rdata_ff[2*WW-1:WW];
      tw_c  = tw_ff[2*TW_W-1:TW_W];
      tw_s  = tw_ff[TW_W-1:0];
      case (cmd.op)
         DP_MUL0: begin mul_w = tw_c; mul_x = b_re_ff; end
         DP_MUL1: begin mul_w = tw_s; mul_x = b_im_ff; end
         DP_MUL2: begin mul_w = tw_c; mul_x = b_im_ff; end
         DP_MUL3: begin mul_w = tw_s; mul_x = b_re_ff; end
         default: begin mul_w = tw_c; mul_x = b_re_ff; end
      endcase
      p_in = PW'(mul_w) * PW'(mul_x);
      {sc_clip_re, sc_re} = scale_clamp(rd_re, cmd.fwd);
      {sc_clip_im, sc_im} = scale_clamp(rd_im, cmd.fwd);

      wr_en   = 1'b1;
      wr_data = rdata_ff;
      case (cmd.op)
         DP_LOAD:      wr_data = {WW'(req_sample_imag), WW'(req_sample_real)};
         DP_WR_RDATA:  wr_data = rdata_ff;
         DP_WR_A:      wr_data = {a_im_ff, a_re_ff};
         DP_WR_SUM:    wr_data = {bf_round(a_im_ff, ti_ff, 1'b0, cmd.fwd),
                                  bf_round(a_re_ff, tr_ff, 1'b0, cmd.fwd)};
         DP_WR_DIFF:   wr_data = {bf_round(a_im_ff, ti_ff, 1'b1, cmd.fwd),
                                  bf_round(a_re_ff, tr_ff, 1'b1, cmd.fwd)};
         DP_WR_SCALED: wr_data = {WW'(sc_im), WW'(sc_re)};
         default:      wr_en   = 1'b0;
      endcase

      clip_in = clip_ff;
      if (cmd.clear_clip) begin
         clip_in = 1'b0;
      end else if (cmd.op == DP_WR_SCALED) begin
         clip_in = clip_ff | sc_clip_re | sc_clip_im;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
      tw_ff    <= tw_rom[tw_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_ff <= 1'b0;
      end else begin
         clip_ff <= clip_in;
      end
      if (cmd.accept) idx_ff <= req_point_index;
      if (cmd.op == DP_LATCH_A) begin
         a_re_ff <= rd_re;
         a_im_ff <= rd_im;
      end
      if (cmd.op == DP_LATCH_B) begin
         b_re_ff <= rd_re;
         b_im_ff <= rd_im;
      end
      p_ff <= p_in;
      case (cmd.op)
         DP_MUL1: tr_ff <= (PW+1)'(p_ff);
         DP_MUL2: tr_ff <= cmd.fwd ? tr_ff - (PW+1)'(p_ff) : tr_ff + (PW+1)'(p_ff);
         DP_MUL3: ti_ff <= (PW+1)'(p_ff);
         DP_MUL4: ti_ff <= cmd.fwd ? ti_ff + (PW+1)'(p_ff) : ti_ff - (PW+1)'(p_ff);
         default: ;
      endcase
      if (cmd.rsp_load) begin
         bin_re_ff <= cmd.rsp_read ? rd_re[SAMPLE_WIDTH-1:0] : '0;
         bin_im_ff <= cmd.rsp_read ? rd_im[SAMPLE_WIDTH-1:0] : '0;
         eidx_ff   <= cmd.accept ? req_point_index : idx_ff;
         sat_ff    <= clip_ff;
      end
   end

   assign rsp_bin_real     = bin_re_ff;
   assign rsp_bin_imag     = bin_im_ff;
   assign rsp_echoed_index = eidx_ff;
   assign rsp_saturated    = sat_ff;

endmodule

// ----- hw/rtl/radix2_complex_fft_core.sv -----
// Radix-2 decimation-in-time complex FFT core, in place over 2^log2_points points.
// Top level; instantiates r2fft_ctrl and r2fft_dp, uses r2fft_pkg.
//
// Each item is a load (action 0), a transform (1) or a read (2); every item
// returns exactly one result item. A read does one registered memory read. A
// transform runs on one memory read port, one write port and one 28x16 multiplier
// at the default widths. It has three parts: a bit-reversal pass that visits each
// point and reads, latches and writes back each swapped pair, log2(N) stages of
// N/2 butterflies (two reads, a latch of the second operand, the multiply states
// M0 to M4 for the four products, two writes), and a final scaling pass that
// reads and writes each point. Forward output is X/(2N); inverse output is 2*X
// saturated, and any clip raises the saturated flag until the next transform.
// The core takes a new item only in the idle state, and while a result waits only
// when rsp_ready takes it. Configuration must be written only while idle; the
// core itself does not enforce it. Memory contents are undefined until loaded.

module radix2_complex_fft_core
   import r2fft_pkg::*;
#(
   parameter int MAX_LOG2_POINTS = 10,
   parameter int SAMPLE_WIDTH    = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [ACT_W-1:0]               req_action,
   input  logic [MAX_LOG2_POINTS-1:0]     req_point_index,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_real,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_imag,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_bin_real,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_bin_imag,
   output logic [MAX_LOG2_POINTS-1:0]     rsp_echoed_index,
   output logic                           rsp_saturated,
   input  logic                           csr_write_en,
   input  logic [CSR_AW-1:0]              csr_index,
   input  logic [CSR_W-1:0]               csr_wdata
);

   localparam int TWAW = (MAX_LOG2_POINTS > 1) ? MAX_LOG2_POINTS - 1 : 1;

   dp_cmd_type                 cmd;
   logic [MAX_LOG2_POINTS-1:0] rd_addr;
   logic [MAX_LOG2_POINTS-1:0] wr_addr;
   logic [TWAW-1:0]            tw_addr;

   r2fft_ctrl #(
      .MAX_LOG2_POINTS(MAX_LOG2_POINTS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_point_index (req_point_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .cmd             (cmd),
      .rd_addr         (rd_addr),
      .wr_addr         (wr_addr),
      .tw_addr         (tw_addr)
   );

   r2fft_dp #(
      .MAX_LOG2_POINTS(MAX_LOG2_POINTS),
      .SAMPLE_WIDTH   (SAMPLE_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .rd_addr          (rd_addr),
      .wr_addr          (wr_addr),
      .tw_addr          (tw_addr),
      .req_point_index  (req_point_index),
      .req_sample_real  (req_sample_real),
      .req_sample_imag  (req_sample_imag),
      .rsp_bin_real     (rsp_bin_real),
      .rsp_bin_imag     (rsp_bin_imag),
      .rsp_echoed_index (rsp_echoed_index),
      .rsp_saturated    (rsp_saturated)
   );

   // a stalled result blocks new items
   a_no_accept_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("item accepted while result stalled");

   // a load answers in the next cycle
   a_load_answers: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_action == ACT_LOAD) |=> rsp_valid)
      else $error("load item gave no result");

   // a transform keeps the core busy
   a_transform_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_action == ACT_TRANSFORM) |=> (!req_ready && !rsp_valid))
      else $error("transform item did not start the sequencer");

endmodule
